// ===== design/status_led_policy_blinker_assert.svh =====
// ---------------------------------------------------------------------------
// status led policy blinker assertion macros
// concurrent assertion wrappers used by the checker file slpb_checker
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_POLICY_BLINKER_ASSERT_SVH
`define STATUS_LED_POLICY_BLINKER_ASSERT_SVH

// assertion that is switched off while reset is high
`define SLPB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("status led policy blinker assertion failed");

// assertion that is also checked during reset
`define SLPB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("status led policy blinker assertion failed");

`endif

// ===== design/slpb_pkg.sv =====
// ---------------------------------------------------------------------------
// slpb_pkg
// shared types, codes and constants of the status led policy blinker
// ---------------------------------------------------------------------------
package slpb_pkg;

   // default number of driven leds
   localparam int LED_COUNT_DEF = 2;

   // field and bus widths
   localparam int COLOR_W    = 3;
   localparam int CODE_W     = 4;
   localparam int TICK_W     = 8;
   localparam int PCT_W      = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   // remainder unit: one dividend bit per cycle, counter + 1 needs nine bits
   localparam int DIV_W     = TICK_W + 1;
   localparam int DIV_CNT_W = 4;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(DIV_W - 1);

   // transaction kinds carried in tuser
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_PULSE  = 1'b1;

   // charge state codes
   localparam logic [2:0] CS_CHARGING       = 3'd0;
   localparam logic [2:0] CS_NEAR_FULL      = 3'd1;
   localparam logic [2:0] CS_DISCHARGE_FULL = 3'd2;
   localparam logic [2:0] CS_ERROR          = 3'd3;

   // system state codes
   localparam logic [1:0] SYS_ON      = 2'd1;
   localparam logic [1:0] SYS_SUSPEND = 2'd2;

   // led codes: off, or colour index plus one
   localparam logic [CODE_W-1:0]  CODE_OFF = 4'd0;
   localparam logic [CODE_W-1:0]  MAX_CODE = 4'd6;
   localparam logic [COLOR_W-1:0] LED_OFF  = 3'd0;

   // battery thresholds in percent
   localparam logic [PCT_W-1:0] CRIT_PCT = 7'd3;
   localparam logic [PCT_W-1:0] LOW_PCT  = 7'd10;

   // fixed blink patterns (on ticks, period ticks)
   localparam logic [TICK_W-1:0] FAST_ON      = 8'd2;
   localparam logic [TICK_W-1:0] FAST_PERIOD  = 8'd4;
   localparam logic [TICK_W-1:0] SLOW_ON      = 8'd8;
   localparam logic [TICK_W-1:0] SLOW_PERIOD  = 8'd16;
   localparam logic [TICK_W-1:0] SUSP_ON      = 8'd4;
   localparam logic [TICK_W-1:0] SUSP_PERIOD  = 8'd16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE_COLOR      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEAR_FULL_COLOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_COLOR       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_BATT_COLOR    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SOC_ON_COLOR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SOC_SUSPEND_COLOR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_ON_TICKS    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_PERIOD      = 3'd7;

   // register reset values
   localparam logic [COLOR_W-1:0] RST_CHARGE_COLOR      = 3'd5;
   localparam logic [COLOR_W-1:0] RST_NEAR_FULL_COLOR   = 3'd1;
   localparam logic [COLOR_W-1:0] RST_ERROR_COLOR       = 3'd0;
   localparam logic [COLOR_W-1:0] RST_LOW_BATT_COLOR    = 3'd5;
   localparam logic [COLOR_W-1:0] RST_SOC_ON_COLOR      = 3'd4;
   localparam logic [COLOR_W-1:0] RST_SOC_SUSPEND_COLOR = 3'd4;
   localparam logic [TICK_W-1:0]  RST_ERROR_ON_TICKS    = 8'd1;
   localparam logic [TICK_W-1:0]  RST_ERROR_PERIOD      = 8'd2;
   localparam logic [TICK_W-1:0]  RST_PULSE_LEN         = 8'd1;

   // controller to datapath commands
   typedef struct packed {
      logic accept;
      logic eval;
      logic div_step;
      logic load_out;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic step_req;
      logic div_last;
   } status_type;

endpackage

// ===== design/slpb_ctrl.sv =====
// ---------------------------------------------------------------------------
// slpb_ctrl
// sequencer: accept, evaluate, remainder iterations, result hand-off
// ---------------------------------------------------------------------------
module slpb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output slpb_pkg::cmd_type    cmd,
   input  slpb_pkg::status_type status
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EVAL = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.step_req ? S_DIV : S_OUT;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register valid: set on load, cleared when the transaction is taken
   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/slpb_datapath.sv =====
// ---------------------------------------------------------------------------
// slpb_datapath
// registers, priority rule, blink state and bit-serial period remainder
// ---------------------------------------------------------------------------
module slpb_datapath #(
   parameter int LED_COUNT = slpb_pkg::LED_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  slpb_pkg::cmd_type                   cmd,
   output slpb_pkg::status_type                status,
   input  logic                                req_tuser,
   input  logic [slpb_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_write,
   input  logic [slpb_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slpb_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [slpb_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam logic HAS_LED1 = (LED_COUNT >= 2);

   // configuration registers
   logic [slpb_pkg::COLOR_W-1:0] charge_color_ff, near_full_color_ff, error_color_ff;
   logic [slpb_pkg::COLOR_W-1:0] low_batt_color_ff, soc_on_color_ff, soc_suspend_color_ff;
   logic [slpb_pkg::TICK_W-1:0]  error_on_ticks_ff, error_period_ff;

   // captured transaction
   logic                         func_ff, present_ff, en0_ff, en1_ff;
   logic [2:0]                   cs_ff;
   logic [slpb_pkg::PCT_W-1:0]   pct_ff;
   logic [1:0]                   sys_ff;

   // blink and led state
   logic                         active_ff, armed_ff;
   logic [slpb_pkg::TICK_W-1:0]  counter_ff, on_len_ff, len_ff;
   logic [slpb_pkg::COLOR_W-1:0] colour_ff, led0_ff, led1_ff;

   // remainder unit
   logic [slpb_pkg::TICK_W-1:0]    rem_ff;
   logic [slpb_pkg::DIV_W-1:0]     dvd_ff;
   logic [slpb_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [slpb_pkg::DIV_W-1:0]     trial, rem_in;

   logic [slpb_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // evaluation signals
   logic                         clr, do_upd, do_tick, start, step, write_ok, len_zero;
   logic [slpb_pkg::CODE_W-1:0]  solid_code, step_code, show_code;
   logic [slpb_pkg::COLOR_W-1:0] b_colour, act_colour, base0, base1, led0_in, led1_in;
   logic [slpb_pkg::TICK_W-1:0]  b_on, b_len, act_on, act_len, cnt_base;
   logic [slpb_pkg::DIV_W-1:0]   cnt_plus;
   logic                         active_in, armed_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         charge_color_ff      <= slpb_pkg::RST_CHARGE_COLOR;
         near_full_color_ff   <= slpb_pkg::RST_NEAR_FULL_COLOR;
         error_color_ff       <= slpb_pkg::RST_ERROR_COLOR;
         low_batt_color_ff    <= slpb_pkg::RST_LOW_BATT_COLOR;
         soc_on_color_ff      <= slpb_pkg::RST_SOC_ON_COLOR;
         soc_suspend_color_ff <= slpb_pkg::RST_SOC_SUSPEND_COLOR;
         error_on_ticks_ff    <= slpb_pkg::RST_ERROR_ON_TICKS;
         error_period_ff      <= slpb_pkg::RST_ERROR_PERIOD;
      end else if (csr_write) begin
         case (csr_index)
            slpb_pkg::REG_CHARGE_COLOR:      charge_color_ff      <= csr_data[2:0];
            slpb_pkg::REG_NEAR_FULL_COLOR:   near_full_color_ff   <= csr_data[2:0];
            slpb_pkg::REG_ERROR_COLOR:       error_color_ff       <= csr_data[2:0];
            slpb_pkg::REG_LOW_BATT_COLOR:    low_batt_color_ff    <= csr_data[2:0];
            slpb_pkg::REG_SOC_ON_COLOR:      soc_on_color_ff      <= csr_data[2:0];
            slpb_pkg::REG_SOC_SUSPEND_COLOR: soc_suspend_color_ff <= csr_data[2:0];
            slpb_pkg::REG_ERROR_ON_TICKS:    error_on_ticks_ff    <= csr_data;
            slpb_pkg::REG_ERROR_PERIOD:      error_period_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // priority rule on the captured transaction
   always_comb begin
      start      = 1'b0;
      solid_code = slpb_pkg::CODE_OFF;
      b_colour   = error_color_ff;
      b_on       = error_on_ticks_ff;
      b_len      = error_period_ff;
      if (cs_ff == slpb_pkg::CS_CHARGING) begin
         solid_code = {1'b0, charge_color_ff} + 4'd1;
      end else if (cs_ff inside {slpb_pkg::CS_NEAR_FULL, slpb_pkg::CS_DISCHARGE_FULL}) begin
         solid_code = {1'b0, near_full_color_ff} + 4'd1;
      end else if (!present_ff || cs_ff == slpb_pkg::CS_ERROR) begin
         start = 1'b1;
      end else if (pct_ff < slpb_pkg::CRIT_PCT) begin
         start    = 1'b1;
         b_colour = low_batt_color_ff;
         b_on     = slpb_pkg::FAST_ON;
         b_len    = slpb_pkg::FAST_PERIOD;
      end else if (pct_ff < slpb_pkg::LOW_PCT) begin
         start    = 1'b1;
         b_colour = low_batt_color_ff;
         b_on     = slpb_pkg::SLOW_ON;
         b_len    = slpb_pkg::SLOW_PERIOD;
      end else if (sys_ff == slpb_pkg::SYS_ON) begin
         solid_code = {1'b0, soc_on_color_ff} + 4'd1;
      end else if (sys_ff == slpb_pkg::SYS_SUSPEND) begin
         start    = 1'b1;
         b_colour = soc_suspend_color_ff;
         b_on     = slpb_pkg::SUSP_ON;
         b_len    = slpb_pkg::SUSP_PERIOD;
      end
   end

   // pulse tick handling, blink step and led writes
   always_comb begin
      clr     = (func_ff == slpb_pkg::FUNC_PULSE) && armed_ff && !active_ff;
      do_upd  = (func_ff == slpb_pkg::FUNC_UPDATE) || clr;
      do_tick = (func_ff == slpb_pkg::FUNC_PULSE) && armed_ff && active_ff;
      step    = (do_upd && start) || do_tick;

      // a tick after blinking stopped clears the counter and darkens enabled leds
      cnt_base = clr ? '0 : counter_ff;
      base0    = (clr && en0_ff) ? slpb_pkg::LED_OFF : led0_ff;
      base1    = (clr && en1_ff && HAS_LED1) ? slpb_pkg::LED_OFF : led1_ff;

      act_colour = (do_upd && start) ? b_colour : colour_ff;
      act_on     = (do_upd && start) ? b_on : on_len_ff;
      act_len    = (do_upd && start) ? b_len : len_ff;

      step_code = (cnt_base < act_on) ? ({1'b0, act_colour} + 4'd1) : slpb_pkg::CODE_OFF;
      show_code = step ? step_code : solid_code;
      write_ok  = (step || do_upd) && (show_code <= slpb_pkg::MAX_CODE);

      led0_in = (write_ok && en0_ff) ? show_code[2:0] : base0;
      led1_in = (write_ok && en1_ff && HAS_LED1) ? show_code[2:0] : base1;

      active_in = do_upd ? start : active_ff;
      armed_in  = step ? 1'b1 : (clr ? 1'b0 : armed_ff);

      cnt_plus = {1'b0, cnt_base} + 9'd1;
      len_zero = (act_len == '0);
   end

   assign status.step_req = step && !len_zero;
   assign status.div_last = (div_cnt_ff == '0);

   // restoring remainder step, one dividend bit per cycle
   assign trial  = {rem_ff, dvd_ff[slpb_pkg::DIV_W-1]};
   assign rem_in = (trial >= {1'b0, len_ff}) ? (trial - {1'b0, len_ff}) : trial;

   // blink and led state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         armed_ff   <= 1'b0;
         counter_ff <= '0;
         colour_ff  <= '0;
         on_len_ff  <= '0;
         len_ff     <= slpb_pkg::RST_PULSE_LEN;
         led0_ff    <= slpb_pkg::LED_OFF;
         led1_ff    <= slpb_pkg::LED_OFF;
      end else if (cmd.eval) begin
         active_ff  <= active_in;
         armed_ff   <= armed_in;
         led0_ff    <= led0_in;
         led1_ff    <= led1_in;
         counter_ff <= (step && len_zero) ? cnt_plus[slpb_pkg::TICK_W-1:0] : cnt_base;
         if (do_upd && start) begin
            colour_ff <= b_colour;
            on_len_ff <= b_on;
            len_ff    <= b_len;
         end
      end else if (cmd.div_step && status.div_last) begin
         counter_ff <= rem_in[slpb_pkg::TICK_W-1:0];
      end
   end

   // payload: captured fields, remainder registers, result register
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff    <= req_tuser;
         cs_ff      <= req_tdata[2:0];
         present_ff <= req_tdata[3];
         pct_ff     <= req_tdata[10:4];
         sys_ff     <= req_tdata[12:11];
         en0_ff     <= req_tdata[13];
         en1_ff     <= req_tdata[14];
      end
      if (cmd.eval) begin
         rem_ff     <= '0;
         dvd_ff     <= cnt_plus;
         div_cnt_ff <= slpb_pkg::DIV_LAST_CNT;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_in[slpb_pkg::TICK_W-1:0];
         dvd_ff     <= {dvd_ff[slpb_pkg::DIV_W-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff - 1'b1;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {1'b0, active_ff, led1_ff, led0_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== design/status_led_policy_blinker.sv =====
// ---------------------------------------------------------------------------
// status_led_policy_blinker
// flow: accept, evaluate, then the bit-serial remainder steps when a blink step runs
//   with a nonzero period, then the result is loaded into the output register
// one transaction at a time: no new request is taken until the result is loaded
// reset: synchronous; registers take their reset values, leds off, no blink
// ---------------------------------------------------------------------------
module status_led_policy_blinker #(
   parameter int LED_COUNT = slpb_pkg::LED_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tuser: func
   // req_tdata: chg_state[2:0], battery_present[3], battery_percent[10:4],
   //            system_state[12:11], auto_led0[13], auto_led1[14], zero[15]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,
   input  logic [slpb_pkg::REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: led0_color[2:0], led1_color[5:3], blinking[6], zero[7]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [slpb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [slpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slpb_pkg::CSR_DATA_W-1:0] csr_data
);

   slpb_pkg::cmd_type    cmd;
   slpb_pkg::status_type status;

   // register writes are always taken
   assign csr_ready = 1'b1;

   slpb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   slpb_datapath #(
      .LED_COUNT (LED_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== design/slpb_checker.sv =====
// ---------------------------------------------------------------------------
// slpb_checker
// port-level checks of the status led policy blinker, bound to the top level
// ---------------------------------------------------------------------------
`include "status_led_policy_blinker_assert.svh"

module slpb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [slpb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds its data
   `SLPB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // one transaction at a time: input closes right after an accept
   `SLPB_ASSERT(a_req_one_at_a_time, clock, reset, req_tvalid && req_tready |=> !req_tready)

   // shown led codes never exceed the last colour and the spare bit stays zero
   `SLPB_ASSERT(a_rsp_codes, clock, reset, rsp_tvalid |-> rsp_tdata[2:0] != 3'd7 && rsp_tdata[5:3] != 3'd7 && !rsp_tdata[7])

   // no result is pending right after reset
   `SLPB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind status_led_policy_blinker slpb_checker u_slpb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
